>>> src/rne_pkg.sv
// rne_pkg: shared types, constants and digit/letter tables for the Roman numeral encoder.
// No dependencies.
package rne_pkg;

	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAw    = $clog2(FifoDepth);

	localparam logic [11:0] MaxValue = 12'd3999;

	localparam logic [6:0] ChC = 7'h43;
	localparam logic [6:0] ChD = 7'h44;
	localparam logic [6:0] ChI = 7'h49;
	localparam logic [6:0] ChL = 7'h4C;
	localparam logic [6:0] ChM = 7'h4D;
	localparam logic [6:0] ChV = 7'h56;
	localparam logic [6:0] ChX = 7'h58;

	// digit places, most significant first
	typedef enum logic [1:0] {
		PL_THOU = 2'd0,
		PL_HUND = 2'd1,
		PL_TENS = 2'd2,
		PL_ONES = 2'd3
	} place_t;

	// letter role inside one digit form
	typedef enum logic [1:0] {
		POS_ONE  = 2'd0,
		POS_FIVE = 2'd1,
		POS_TEN  = 2'd2
	} pos_t;

	typedef struct packed {
		logic [1:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	function automatic logic [2:0] form_len(input logic [3:0] d);
		logic [2:0] n;
		unique case (d)
			4'd0:    n = 3'd0;
			4'd1:    n = 3'd1;
			4'd2:    n = 3'd2;
			4'd3:    n = 3'd3;
			4'd4:    n = 3'd2;
			4'd5:    n = 3'd1;
			4'd6:    n = 3'd2;
			4'd7:    n = 3'd3;
			4'd8:    n = 3'd4;
			4'd9:    n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic pos_t form_pos(input logic [3:0] d, input logic [1:0] k);
		pos_t p;
		unique case (d)
			4'd4:                p = (k == 2'd0) ? POS_ONE : POS_FIVE;
			4'd5:                p = POS_FIVE;
			4'd6, 4'd7, 4'd8:    p = (k == 2'd0) ? POS_FIVE : POS_ONE;
			4'd9:                p = (k == 2'd0) ? POS_ONE : POS_TEN;
			default:             p = POS_ONE;
		endcase
		return p;
	endfunction

	function automatic logic [6:0] letter(input place_t pl, input pos_t p);
		logic [6:0] c;
		unique case (pl)
			PL_THOU: c = ChM;
			PL_HUND: c = (p == POS_ONE) ? ChC : (p == POS_FIVE) ? ChD : ChM;
			PL_TENS: c = (p == POS_ONE) ? ChX : (p == POS_FIVE) ? ChL : ChC;
			PL_ONES: c = (p == POS_ONE) ? ChI : (p == POS_FIVE) ? ChV : ChX;
			default: c = ChM;
		endcase
		return c;
	endfunction

endpackage

>>> src/rne_front.sv
// rne_front: three-stage input pipeline; saturates, splits into decimal digits, drops zeros.
// Depends on rne_pkg.
module rne_front import rne_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] value,
	input  logic        fifo_full,
	output logic        fifo_wr,
	output digits_t     fifo_wdata
);

	logic        v_s1, v_s2, v_s3;
	logic        nz_s1, nz_s2, nz_s3;
	logic [1:0]  thou_s1, thou_s2, thou_s3;
	logic [9:0]  rem_s1;
	logic [3:0]  hund_s2, hund_s3;
	logic [6:0]  rem_s2;
	logic [3:0]  tens_s3, ones_s3;

	logic        rdy1, rdy2, rdy3, acc;
	logic [11:0] vsat;
	logic [1:0]  th_c;
	logic [11:0] th_base;
	logic [3:0]  hu_c;
	logic [9:0]  hu_base;
	logic [3:0]  te_c;
	logic [6:0]  te_base;

	assign rdy3 = !v_s3 || !nz_s3 || !fifo_full;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign full = !rdy1;
	assign acc  = push && rdy1;

	assign fifo_wr    = v_s3 && nz_s3 && !fifo_full;
	assign fifo_wdata = '{thou: thou_s3, hund: hund_s3, tens: tens_s3, ones: ones_s3};

	always_comb begin
		vsat = (value > MaxValue) ? MaxValue : value;
		priority if (vsat >= 12'd3000) begin
			th_c = 2'd3; th_base = 12'd3000;
		end else if (vsat >= 12'd2000) begin
			th_c = 2'd2; th_base = 12'd2000;
		end else if (vsat >= 12'd1000) begin
			th_c = 2'd1; th_base = 12'd1000;
		end else begin
			th_c = 2'd0; th_base = 12'd0;
		end
	end

	always_comb begin
		hu_c = 4'd0;
		hu_base = 10'd0;
		for (int i = 1; i < 10; i++) begin
			if (rem_s1 >= 10'(i * 100)) begin
				hu_c = 4'(i);
				hu_base = 10'(i * 100);
			end
		end
	end

	always_comb begin
		te_c = 4'd0;
		te_base = 7'd0;
		for (int i = 1; i < 10; i++) begin
			if (rem_s2 >= 7'(i * 10)) begin
				te_c = 4'(i);
				te_base = 7'(i * 10);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= push;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			nz_s1   <= (value != 12'd0);
			thou_s1 <= th_c;
			rem_s1  <= 10'(vsat - th_base);
		end
		if (rdy2 && v_s1) begin
			nz_s2   <= nz_s1;
			thou_s2 <= thou_s1;
			hund_s2 <= hu_c;
			rem_s2  <= 7'(rem_s1 - hu_base);
		end
		if (rdy3 && v_s2) begin
			nz_s3   <= nz_s2;
			thou_s3 <= thou_s2;
			hund_s3 <= hund_s2;
			tens_s3 <= te_c;
			ones_s3 <= 4'(rem_s2 - te_base);
		end
	end

endmodule

>>> src/rne_fifo.sv
// rne_fifo: short digit queue between the front pipeline and the character sequencer.
// Depends on rne_pkg.
module rne_fifo import rne_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  digits_t wdata,
	input  logic    rd,
	output digits_t rdata,
	output logic    not_empty,
	output logic    is_full
);

	digits_t           mem [FifoDepth];
	logic [FifoAw-1:0] wp_q, rp_q;
	logic [FifoAw:0]   cnt_q;

	assign not_empty = (cnt_q != '0);
	assign is_full   = (cnt_q == (FifoAw+1)'(FifoDepth));
	assign rdata     = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/rne_back.sv
// rne_back: character sequencer; walks the nonzero digits of one value, one letter per beat,
// into a registered output slot. Depends on rne_pkg.
module rne_back import rne_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fifo_ne,
	input  digits_t    fifo_rdata,
	output logic       fifo_rd,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] symbol,
	output logic       final_symbol
);

	logic [3:0] dig_q [4];
	logic [1:0] k_q;
	logic       cur_v_q;
	logic       out_v_q;
	logic [6:0] sym_q;
	logic       fin_q;

	place_t     pl;
	logic       found, rest;
	logic [3:0] cur_d;
	logic [2:0] len;
	logic       last_dig, fin, fire, ld;
	logic [6:0] ch;

	always_comb begin
		pl = PL_THOU;
		found = 1'b0;
		rest = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (found && dig_q[i] != 4'd0) rest = 1'b1;
			if (!found && dig_q[i] != 4'd0) begin
				pl = place_t'(2'(i));
				found = 1'b1;
			end
		end
		cur_d    = dig_q[pl];
		len      = form_len(cur_d);
		last_dig = ({1'b0, k_q} == len - 3'd1);
		fin      = last_dig && !rest;
		ch       = letter(pl, form_pos(cur_d, k_q));
		fire     = cur_v_q && (!out_v_q || pop);
		ld       = fifo_ne && (!cur_v_q || (fire && fin));
	end

	assign fifo_rd      = ld;
	assign empty        = !out_v_q;
	assign symbol       = sym_q;
	assign final_symbol = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			k_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (ld) begin
				cur_v_q <= 1'b1;
				k_q     <= '0;
			end else if (fire) begin
				k_q <= last_dig ? 2'd0 : k_q + 2'd1;
				if (fin) cur_v_q <= 1'b0;
			end
			if (fire) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			dig_q[0] <= {2'b00, fifo_rdata.thou};
			dig_q[1] <= fifo_rdata.hund;
			dig_q[2] <= fifo_rdata.tens;
			dig_q[3] <= fifo_rdata.ones;
		end else if (fire && last_dig) begin
			dig_q[pl] <= 4'd0;
		end
		if (fire) begin
			sym_q <= ch;
			fin_q <= fin;
		end
	end

endmodule

>>> src/roman_numeral_encoder_unit.sv
// roman_numeral_encoder_unit: top level; front digit splitter, digit queue, letter sequencer.
// Depends on rne_pkg, rne_front, rne_fifo, rne_back.
//
//   channel | handshake    | ports
//   --------+--------------+---------------------------
//   in      | push / full  | value[11:0]
//   out     | pop / empty  | symbol[6:0], final_symbol
//
// One beat out per cycle while pop takes each beat, set by the single-letter output slot of the
// sequencer; a value gives as many beats as its numeral has letters (1 to 15). A zero value
// produces no beat and is dropped by the front without a queue write. Reset clears only
// control state; no clearing pass. A stalled output backs up into the four-entry digit
// queue and then the three front stages before full rises.
module roman_numeral_encoder_unit import rne_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [11:0] value,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  symbol,
	output logic        final_symbol
);

	logic    f_wr, f_rd, f_ne, f_full;
	digits_t f_wdata, f_rdata;

	rne_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.value      (value),
		.fifo_full  (f_full),
		.fifo_wr    (f_wr),
		.fifo_wdata (f_wdata)
	);

	rne_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (f_wr),
		.wdata     (f_wdata),
		.rd        (f_rd),
		.rdata     (f_rdata),
		.not_empty (f_ne),
		.is_full   (f_full)
	);

	rne_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_ne      (f_ne),
		.fifo_rdata   (f_rdata),
		.fifo_rd      (f_rd),
		.empty        (empty),
		.pop          (pop),
		.symbol       (symbol),
		.final_symbol (final_symbol)
	);

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_wr && f_full)) else $error("digit queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_rd && !f_ne)) else $error("digit queue read while empty");

	a_legal_letter: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (symbol == ChC || symbol == ChD || symbol == ChI || symbol == ChL ||
			symbol == ChM || symbol == ChV || symbol == ChX))
		else $error("illegal letter on output");

	a_load_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		f_rd |=> !f_full) else $error("queue still full after a read");
`endif

endmodule
